// ===== sv/lprb_pkg.sv =====
// shared types, constants and codes for the length-prefixed packet ring buffer
// used by the channel interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package lprb_pkg;

   localparam int DEF_RING_BYTES       = 256;
   localparam int DEF_MAX_PACKET_BYTES = 48;

   localparam int BYTE_W   = 8;
   localparam int RSSI_W   = 9;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 2;
   // stored length byte value (data length plus 2) fits in this many bits
   localparam int PLEN_W   = 7;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_BAD_LEN = 2'd2;
   localparam status_type ST_EMPTY   = 2'd3;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef struct packed {
      logic start_pkt;      // accepted first byte: write length byte, open packet
      logic reject_pkt;     // rejected first byte: close any open packet
      logic wr_mag;         // write rssi magnitude byte
      logic wr_first_data;  // write first data byte
      logic wr_data_in;     // write a later data byte of the open packet
      logic load_status;    // load a write status result
      logic load_empty;     // load an empty-buffer result
      logic rd_start;       // fetch length byte at the read pointer
      logic rd_len;         // latch length, fetch magnitude byte
      logic rd_mag;         // latch magnitude, fetch first data byte
      logic load_byte;      // load a read result from the fetched byte
      logic rd_next;        // fetch the next data byte
      logic commit_read;    // release the packet just read
   } cmd_type;

   typedef struct packed {
      logic start_ok;  // first byte passes length and space checks
      logic empty;     // no complete packet stored
      logic open;      // data bytes still expected for the open packet
      logic rem_last;  // the byte being emitted is the last of the packet
   } stat_type;

endpackage

`default_nettype wire

// ===== sv/lprb_if.sv =====
// request and response channel interfaces with valid/ready handshake
// depends on lprb_pkg for the payload widths
`timescale 1ns / 1ps
`default_nettype none

interface lprb_req_if import lprb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic                     first;
   logic        [BYTE_W-1:0] pkt_len;
   logic signed [RSSI_W-1:0] rssi;
   logic        [BYTE_W-1:0] data_in;

   modport source (output valid, action, first, pkt_len, rssi, data_in, input ready);
   modport sink   (input valid, action, first, pkt_len, rssi, data_in, output ready);
endinterface

interface lprb_rsp_if import lprb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   status_type               status;
   logic        [BYTE_W-1:0] data_out;
   logic signed [RSSI_W-1:0] rssi_out;
   logic        [LEN_W-1:0]  length_out;
   logic                     last;

   modport source (output valid, kind, status, data_out, rssi_out, length_out, last,
                   input ready);
   modport sink   (input valid, kind, status, data_out, rssi_out, length_out, last,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/lprb_ctrl.sv =====
// controller state machine: handshakes, sequencing of header writes and packet reads
// depends on lprb_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module lprb_ctrl import lprb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_action,
   input  logic     req_first,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_W_MAG  = 6'b000010,
      S_W_DAT  = 6'b000100,
      S_R_LEN  = 6'b001000,
      S_R_MAG  = 6'b010000,
      S_R_DATA = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;
   logic      load;

   // output register can take a result now or at this edge
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_action == ACT_WRITE) begin
                  if (req_first) begin
                     cmd.load_status = 1'b1;
                     if (stat.start_ok) begin
                        cmd.start_pkt = 1'b1;
                        state_in      = S_W_MAG;
                     end else begin
                        cmd.reject_pkt = 1'b1;
                     end
                  end else begin
                     cmd.wr_data_in = stat.open;
                  end
               end else begin
                  if (stat.empty) begin
                     cmd.load_empty = 1'b1;
                  end else begin
                     cmd.rd_start = 1'b1;
                     state_in     = S_R_LEN;
                  end
               end
            end
         end
         S_W_MAG: begin
            cmd.wr_mag = 1'b1;
            state_in   = S_W_DAT;
         end
         S_W_DAT: begin
            cmd.wr_first_data = 1'b1;
            state_in          = S_IDLE;
         end
         S_R_LEN: begin
            cmd.rd_len = 1'b1;
            state_in   = S_R_MAG;
         end
         S_R_MAG: begin
            cmd.rd_mag = 1'b1;
            state_in   = S_R_DATA;
         end
         S_R_DATA: begin
            if (out_free) begin
               cmd.load_byte = 1'b1;
               if (stat.rem_last) begin
                  cmd.commit_read = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign load = cmd.load_status || cmd.load_empty || cmd.load_byte;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lprb_datapath.sv =====
// datapath: ring memory, pointers, free-space count, header checks, result register
// depends on lprb_pkg; driven by commands from lprb_ctrl
`timescale 1ns / 1ps
`default_nettype none

module lprb_datapath import lprb_pkg::*; #(
   parameter int RING_BYTES       = DEF_RING_BYTES,
   parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic        [BYTE_W-1:0] req_pkt_len,
   input  logic signed [RSSI_W-1:0] req_rssi,
   input  logic        [BYTE_W-1:0] req_data_in,
   output logic                     rsp_kind,
   output status_type               rsp_status,
   output logic        [BYTE_W-1:0] rsp_data_out,
   output logic signed [RSSI_W-1:0] rsp_rssi_out,
   output logic        [LEN_W-1:0]  rsp_length_out,
   output logic                     rsp_last
);

   localparam int AW = $clog2(RING_BYTES);
   localparam int FW = $clog2(RING_BYTES + 1);
   localparam int CW = (FW > 9) ? FW : 9;

   localparam logic [AW:0]        RING_X    = (AW + 1)'(RING_BYTES);
   localparam logic [FW-1:0]      RING_FULL = FW'(RING_BYTES);
   localparam logic [BYTE_W-1:0]  MAX_LEN   = BYTE_W'(MAX_PACKET_BYTES);
   localparam logic [BYTE_W-1:0]  PLEN_LO   = BYTE_W'(3);
   localparam logic [BYTE_W-1:0]  PLEN_HI   = BYTE_W'(MAX_PACKET_BYTES + 2);
   localparam logic [PLEN_W-1:0]  ONE_P     = PLEN_W'(1);

   // a + b modulo the ring size, b is always below the ring size
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                              input logic [PLEN_W-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + (AW + 1)'(b);
      if (s >= RING_X) begin
         s = s - RING_X;
      end
      return s[AW-1:0];
   endfunction

   logic [BYTE_W-1:0] ring_mem [RING_BYTES];

   // control state
   logic [AW-1:0]     wp_ff, wp_in;
   logic [AW-1:0]     rp_ff, rp_in;
   logic [FW-1:0]     free_ff, free_in;
   logic [LEN_W-1:0]  btc_ff, btc_in;

   // working registers
   logic [PLEN_W-1:0] plen_wr_ff;
   logic [AW-1:0]     wr_addr_ff;
   logic [BYTE_W-1:0] hdr_mag_ff;
   logic [BYTE_W-1:0] hdr_data_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic [PLEN_W-1:0] rd_plen_ff;
   logic [LEN_W-1:0]  rd_dlen_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [BYTE_W-1:0] rd_mag_ff;
   logic [BYTE_W-1:0] rdata_ff;

   logic              len_bad;
   logic              no_room;
   logic [8:0]        need;
   status_type        status_code;
   logic [9:0]        neg_mag;
   logic [BYTE_W-1:0] mag;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [BYTE_W-1:0] wdata;
   logic              re;
   logic [AW-1:0]     raddr;
   logic              commit_wr;
   logic [PLEN_W-1:0] plen_clamp;
   logic [FW:0]       free_sum;

   // header checks on the first byte
   assign len_bad     = (req_pkt_len == '0) || (req_pkt_len > MAX_LEN);
   assign need        = {1'b0, req_pkt_len} + 9'd2;
   assign no_room     = CW'(free_ff) < CW'(need);
   assign status_code = len_bad ? ST_BAD_LEN : (no_room ? ST_FULL : ST_OK);

   // magnitude of the rssi, saturated to one byte
   assign neg_mag = 10'd512 - {1'b0, req_rssi};
   always_comb begin
      if (req_rssi[RSSI_W-1]) begin
         mag = (neg_mag > 10'd255) ? 8'hFF : neg_mag[BYTE_W-1:0];
      end else begin
         mag = req_rssi[BYTE_W-1:0];
      end
   end

   assign stat.start_ok = !len_bad && !no_room;
   assign stat.empty    = (free_ff == RING_FULL);
   assign stat.open     = (btc_ff != '0);
   assign stat.rem_last = (rem_ff == LEN_W'(1));

   // single write port
   assign we    = cmd.start_pkt || cmd.wr_mag || cmd.wr_first_data || cmd.wr_data_in;
   assign waddr = cmd.start_pkt ? wp_ff : wr_addr_ff;
   always_comb begin
      if (cmd.start_pkt) begin
         wdata = req_pkt_len + 8'd2;
      end else if (cmd.wr_mag) begin
         wdata = hdr_mag_ff;
      end else if (cmd.wr_first_data) begin
         wdata = hdr_data_ff;
      end else begin
         wdata = req_data_in;
      end
   end

   assign re    = cmd.rd_start || cmd.rd_len || cmd.rd_mag || cmd.rd_next;
   assign raddr = cmd.rd_start ? rp_ff : rd_addr_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         ring_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= ring_mem[raddr];
      end
   end

   // packet becomes readable once its last data byte is stored
   assign commit_wr = (cmd.wr_first_data && (btc_ff == '0)) ||
                      (cmd.wr_data_in && (btc_ff == LEN_W'(1)));

   always_comb begin
      if (rdata_ff < PLEN_LO) begin
         plen_clamp = PLEN_LO[PLEN_W-1:0];
      end else if (rdata_ff > PLEN_HI) begin
         plen_clamp = PLEN_HI[PLEN_W-1:0];
      end else begin
         plen_clamp = rdata_ff[PLEN_W-1:0];
      end
   end

   assign free_sum = {1'b0, free_ff} + (FW + 1)'(rd_plen_ff);

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      free_in = free_ff;
      btc_in  = btc_ff;
      if (cmd.start_pkt) begin
         btc_in = req_pkt_len[LEN_W-1:0] - LEN_W'(1);
      end else if (cmd.reject_pkt) begin
         btc_in = '0;
      end else if (cmd.wr_data_in) begin
         btc_in = btc_ff - LEN_W'(1);
      end
      if (commit_wr) begin
         wp_in   = ring_add(wp_ff, plen_wr_ff);
         free_in = free_ff - FW'(plen_wr_ff);
      end
      if (cmd.commit_read) begin
         rp_in   = ring_add(rp_ff, rd_plen_ff);
         free_in = (free_sum > (FW + 1)'(RING_BYTES)) ? RING_FULL : free_sum[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         free_ff <= RING_FULL;
         btc_ff  <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         free_ff <= free_in;
         btc_ff  <= btc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_pkt) begin
         plen_wr_ff  <= req_pkt_len[PLEN_W-1:0] + PLEN_W'(2);
         hdr_mag_ff  <= mag;
         hdr_data_ff <= req_data_in;
         wr_addr_ff  <= ring_add(wp_ff, ONE_P);
      end else if (cmd.wr_mag || cmd.wr_first_data || cmd.wr_data_in) begin
         wr_addr_ff <= ring_add(wr_addr_ff, ONE_P);
      end
      if (re) begin
         rd_addr_ff <= ring_add(raddr, ONE_P);
      end
      if (cmd.rd_len) begin
         rd_plen_ff <= plen_clamp;
         rd_dlen_ff <= LEN_W'(plen_clamp - PLEN_W'(2));
         rem_ff     <= LEN_W'(plen_clamp - PLEN_W'(2));
      end else if (cmd.load_byte) begin
         rem_ff <= rem_ff - LEN_W'(1);
      end
      if (cmd.rd_mag) begin
         rd_mag_ff <= rdata_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_status) begin
         rsp_kind       <= KIND_STATUS;
         rsp_status     <= status_code;
         rsp_data_out   <= '0;
         rsp_rssi_out   <= req_rssi;
         rsp_length_out <= len_bad ? '0 : req_pkt_len[LEN_W-1:0];
         rsp_last       <= 1'b1;
      end else if (cmd.load_empty) begin
         rsp_kind       <= KIND_READ;
         rsp_status     <= ST_EMPTY;
         rsp_data_out   <= '0;
         rsp_rssi_out   <= '0;
         rsp_length_out <= '0;
         rsp_last       <= 1'b1;
      end else if (cmd.load_byte) begin
         rsp_kind       <= KIND_READ;
         rsp_status     <= ST_OK;
         rsp_data_out   <= rdata_ff;
         rsp_rssi_out   <= $signed(RSSI_W'(9'd0 - {1'b0, rd_mag_ff}));
         rsp_length_out <= rd_dlen_ff;
         rsp_last       <= stat.rem_last;
      end
   end

endmodule

`default_nettype wire

// ===== sv/length_prefixed_packet_ring_buffer.sv =====
// Received-packet FIFO in a byte ring. Requests come on req_chan, results leave on
// rsp_chan, both valid/ready; a request moves when valid and ready are high together.
// A write request (action 0) with first set carries the packet length and rssi with
// its first data byte: one status result follows (ok, full, or invalid length).
// Later write requests carry one data byte each and give no result.
// A read request (action 1) pops the oldest complete packet and gives one result per
// data byte, last set on the final one, or a single empty result.
// Per request: a later data byte is written as it is accepted; an accepted first
// byte blocks new requests while the single memory write port stores the length
// byte, the rssi byte and the first data byte one after another; a refused first
// byte writes nothing; a read makes two header fetches through the registered memory
// read, then gives one byte a cycle while the receiver keeps up.
// Results are registered and appear in the cycle after they are formed.
// When the receiver stalls, the result register holds and req_chan.ready stays low
// until it is taken; a read pauses between bytes.
// Reset (synchronous) empties the ring and clears the pointers; memory contents are
// not cleared and need no clearing pass.
// depends on lprb_pkg, lprb_if, lprb_ctrl and lprb_datapath
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_packet_ring_buffer import lprb_pkg::*; #(
   parameter int RING_BYTES       = DEF_RING_BYTES,
   parameter int MAX_PACKET_BYTES = DEF_MAX_PACKET_BYTES
) (
   input logic          clock,
   input logic          reset,
   lprb_req_if.sink     req_chan,
   lprb_rsp_if.source   rsp_chan
);

   cmd_type  cmd;
   stat_type stat;
   logic     req_fire;

   assign req_fire = req_chan.valid && req_chan.ready;

   lprb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_action (req_chan.action),
      .req_first  (req_chan.first),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lprb_datapath #(
      .RING_BYTES       (RING_BYTES),
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_pkt_len    (req_chan.pkt_len),
      .req_rssi       (req_chan.rssi),
      .req_data_in    (req_chan.data_in),
      .rsp_kind       (rsp_chan.kind),
      .rsp_status     (rsp_chan.status),
      .rsp_data_out   (rsp_chan.data_out),
      .rsp_rssi_out   (rsp_chan.rssi_out),
      .rsp_length_out (rsp_chan.length_out),
      .rsp_last       (rsp_chan.last)
   );

   // a read of an empty ring answers at once with the empty status
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.action == ACT_READ) && stat.empty |=>
      rsp_chan.valid && (rsp_chan.status == ST_EMPTY) && rsp_chan.last)
      else $error("empty read did not give an empty result");

   // every first byte gives one status result
   a_first_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_chan.action == ACT_WRITE) && req_chan.first |=>
      rsp_chan.valid && (rsp_chan.kind == KIND_STATUS) && rsp_chan.last)
      else $error("first byte did not give a status result");

   // the memory has one write port
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start_pkt, cmd.wr_mag, cmd.wr_first_data, cmd.wr_data_in}))
      else $error("more than one ring write in a cycle");

endmodule

`default_nettype wire
